// ===== rtl/chunk_overlap_crossfade_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the chunk overlap crossfade unit
// Shared property wrappers, sampled on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef CHUNK_OVERLAP_CROSSFADE_UNIT_DEFINES_SVH
`define CHUNK_OVERLAP_CROSSFADE_UNIT_DEFINES_SVH

// same-cycle implication
`define COC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define COC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/coc_pkg.sv =====
// ----------------------------------------------------------------------------
// coc_pkg
// Codes, fixed widths and the raised-cosine table builder.
// ----------------------------------------------------------------------------
package coc_pkg;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_DRAIN = 2'd1,
    OP_FLUSH = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_BUSY     = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_OVERFLOW = 2'd3
  } status_e;

  localparam logic [1:0] CFG_FRAME     = 2'd0;
  localparam logic [1:0] CFG_LOOKAHEAD = 2'd1;
  localparam logic [1:0] CFG_BLEND     = 2'd2;

  localparam int unsigned FRAME_W = 13;
  localparam int unsigned LOOK_W  = 5;
  localparam int unsigned BLEND_W = 13;
  localparam int unsigned HIST_W  = 7;
  localparam int unsigned PROD_W  = HIST_W + FRAME_W;
  localparam int unsigned CFG_W   = 13;
  localparam int unsigned WGT_W   = 16;

  localparam logic [FRAME_W-1:0] FRAME_RESET = 13'd1024;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;
  localparam logic [63:0] PI_Q30  = 64'd3373259426;

  // Q30 Taylor cosine folded about pi/2, rounded to a Q1.15 Hann weight
  function automatic logic [WGT_W-1:0] hann_entry(logic [63:0] theta, logic rising);
    logic [63:0] t2;
    logic [63:0] h;
    logic [63:0] term;
    logic [63:0] v;
    t2   = (theta * theta) >> 30;
    h    = ONE_Q30;
    term = ((t2 * h) >> 30) / 64'd132;
    h    = (term > ONE_Q30) ? 64'd0 : ONE_Q30 - term;
    term = ((t2 * h) >> 30) / 64'd90;
    h    = (term > ONE_Q30) ? 64'd0 : ONE_Q30 - term;
    term = ((t2 * h) >> 30) / 64'd56;
    h    = (term > ONE_Q30) ? 64'd0 : ONE_Q30 - term;
    term = ((t2 * h) >> 30) / 64'd30;
    h    = (term > ONE_Q30) ? 64'd0 : ONE_Q30 - term;
    term = ((t2 * h) >> 30) / 64'd12;
    h    = (term > ONE_Q30) ? 64'd0 : ONE_Q30 - term;
    term = ((t2 * h) >> 30) / 64'd2;
    h    = (term > ONE_Q30) ? 64'd0 : ONE_Q30 - term;
    v    = rising ? ((ONE_Q30 - h) >> 1) : ((ONE_Q30 + h) >> 1);
    return WGT_W'((v + 64'd16384) >> 15);
  endfunction

endpackage

// ===== rtl/coc_rom.sv =====
// ----------------------------------------------------------------------------
// coc_rom
// Raised-cosine weight table, registered read.
// ----------------------------------------------------------------------------
module coc_rom #(
  parameter int unsigned T = 256
) (
  input  logic                          clk_i,
  input  logic [$clog2(T)-1:0]          idx_i,
  output logic [coc_pkg::WGT_W-1:0]     w_o
);

  localparam int unsigned IW = $clog2(T);

  logic [coc_pkg::WGT_W-1:0] tbl [T];
  logic [coc_pkg::WGT_W-1:0] w_q;

  for (genvar k = 0; k < T; k++) begin : g_tbl
    localparam logic [63:0] LAST  = 64'(T - 1);
    localparam logic [63:0] KK    = 64'(k);
    localparam logic [63:0] M     = (2 * KK <= LAST) ? KK : LAST - KK;
    localparam logic [63:0] THETA = (coc_pkg::PI_Q30 * M + LAST / 2) / LAST;
    assign tbl[k] = coc_pkg::hann_entry(THETA, (2 * KK <= LAST));
  end

  always_ff @(posedge clk_i) begin
    if ({1'b0, idx_i} < (IW+1)'(T)) begin
      w_q <= tbl[idx_i];
    end else begin
      w_q <= '0;
    end
  end

  assign w_o = w_q;

endmodule

// ===== rtl/coc_div.sv =====
// ----------------------------------------------------------------------------
// coc_div
// Restoring divider, one quotient bit per cycle; results hold until restart.
// ----------------------------------------------------------------------------
module coc_div #(
  parameter int unsigned NW = 8,
  parameter int unsigned DW = 14
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o,
  output logic [DW-1:0] rem_o
);

  localparam int unsigned KW = $clog2(NW + 1);

  logic          run_q;
  logic          done_q;
  logic [KW-1:0] cnt_q;
  logic [NW-1:0] dvd_q;
  logic [NW-1:0] quo_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] dsr_q;
  logic [DW:0]   trial;
  logic          ge;
  logic [DW:0]   diff;

  assign trial = {rem_q, dvd_q[NW-1]};
  assign ge    = trial >= {1'b0, dsr_q};
  assign diff  = trial - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= KW'(NW);
    end else if (run_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == KW'(1)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (run_q) begin
      dvd_q <= dvd_q << 1;
      rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
      quo_q <= {quo_q[NW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/chunk_overlap_crossfade_unit.sv =====
// ----------------------------------------------------------------------------
// chunk_overlap_crossfade_unit
// Chunk stitcher with Hann overlap-add crossfade and a pull-style drain queue.
// ----------------------------------------------------------------------------
// Every request returns exactly one result. Load, drain, flush and idle
// opcodes are accepted, then the result register loads from the drain
// memory's registered read port. A chunk end starts a walk over the
// three sample memories during which no request is accepted: the setup
// states, then, when a chunk is already held, a divider run when the
// overlap is two samples or longer and a crossfade pass over the held
// samples, then a copy of the main region into the held store. A bypassed
// chunk walks the whole chunk; a flush walks the held samples. Each walk
// cycle is one read of the source memory and one write behind it, so memory
// port bandwidth sets the walk length. Memories need no clearing.
// ----------------------------------------------------------------------------
module chunk_overlap_crossfade_unit #(
  parameter int unsigned MAX_CHUNK      = 8192,
  parameter int unsigned COS_TABLE_SIZE = 256,
  parameter int unsigned SAMPLE_BITS    = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    opcode_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  input  logic                          chunk_end_i,
  input  logic [coc_pkg::HIST_W-1:0]    history_count_i,
  // result channel
  output logic                          res_valid_o,
  input  logic                          res_stall_i,
  output logic                          out_valid_o,
  output logic signed [SAMPLE_BITS-1:0] sample_out_o,
  output logic                          run_last_o,
  output logic [1:0]                    status_o,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [coc_pkg::CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_CHUNK);
  localparam int unsigned CW = $clog2(MAX_CHUNK + 1);
  localparam int unsigned IW = $clog2(COS_TABLE_SIZE);
  localparam int unsigned WW = (CW > coc_pkg::PROD_W) ? CW : coc_pkg::PROD_W;
  localparam int unsigned SB = SAMPLE_BITS;
  localparam int unsigned SW = SB + 19;
  localparam logic signed [SW-1:0] HALF = SW'(16384);
  localparam logic signed [SW-1:0] SMAX = SW'((64'd1 << (SB - 1)) - 64'd1);
  localparam logic signed [SW-1:0] SMIN = -SMAX - SW'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP1,
    ST_SETUP2,
    ST_SETUP3,
    ST_SETUP4,
    ST_DIV,
    ST_WALK
  } state_e;

  typedef enum logic [1:0] {
    PASS_MIX,    // held -> drain, tail crossfaded with chunk lead
    PASS_KEEP,   // chunk main region -> held
    PASS_BYP,    // whole chunk -> drain
    PASS_FLUSH   // held -> drain
  } pass_e;

  // configuration
  logic [coc_pkg::FRAME_W-1:0] frame_q;
  logic [coc_pkg::LOOK_W-1:0]  look_q;
  logic [coc_pkg::BLEND_W-1:0] blend_q;

  // control state
  state_e        state_q;
  pass_e         pass_q;
  logic [CW-1:0] fill_q, held_len_q, drain_len_q, drain_ptr_q;
  logic          present_q;
  logic [CW-1:0] j_q, len_q, n_q, mb_q, me_q, cb_q, lead_q, off_q;
  logic [AW-1:0] base_q;
  logic [coc_pkg::HIST_W-1:0] hist_q;
  logic [WW-1:0] hs_q, fs_q;
  logic          one_q;
  logic [IW-1:0] wq_q;
  logic [CW-1:0] wr_q;

  // write-behind stage
  logic          p_vld_q, p_mix_q, p_one_q;
  logic [AW-1:0] p_addr_q;

  // result path
  logic          pend_q, pend_vld_q, pend_last_q;
  logic [1:0]    pend_stat_q;
  logic          res_valid_q, out_valid_q, last_q;
  logic [1:0]    status_q;
  logic signed [SB-1:0] sample_q;

  // memories
  logic signed [SB-1:0] chunk_mem [MAX_CHUNK];
  logic signed [SB-1:0] held_mem  [MAX_CHUNK];
  logic signed [SB-1:0] drain_mem [MAX_CHUNK];
  logic signed [SB-1:0] chunk_rd_q, held_rd_q, drain_rd_q;

  // ---- request decode --------------------------------------------------------
  logic               accept;
  logic               busy;
  logic               full;
  logic               bypass;
  coc_pkg::opcode_e   op;
  logic               load_store;
  logic [CW-1:0]      n_new;

  assign in_stall_o = (state_q != ST_IDLE) || pend_q || (res_valid_q && res_stall_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign busy       = drain_ptr_q < drain_len_q;
  assign full       = fill_q == CW'(MAX_CHUNK);
  assign bypass     = (frame_q == '0) || ((look_q == '0) && (blend_q == '0));
  assign op         = coc_pkg::opcode_e'(opcode_i);
  // chunk end while queue busy is refused and the sample is not stored
  assign load_store = accept && (op == coc_pkg::OP_LOAD) && !(chunk_end_i && busy) && !full;
  assign n_new      = full ? fill_q : fill_q + 1'b1;

  // ---- setup arithmetic -------------------------------------------------------
  logic [WW-1:0] n_w;
  logic [CW-1:0] mb_c, me_c, cb_c, ov_c;
  logic [WW-1:0] blend_w;

  assign n_w     = WW'(n_q);
  assign blend_w = WW'(blend_q);
  assign mb_c    = (hs_q < n_w) ? CW'(hs_q) : n_q;
  assign me_c    = (fs_q < n_w) ? CW'(n_w - fs_q) : '0;
  assign cb_c    = (WW'(mb_q) > blend_w) ? CW'(WW'(mb_q) - blend_w) : '0;
  assign ov_c    = (lead_q < held_len_q) ? lead_q : held_len_q;

  // ---- weight index stepping: idx = (i*(T-1) + d/2) / d, d = ov-1 -------------
  logic          div_start, div_done;
  logic [IW-1:0] div_quo;
  logic [CW-1:0] div_rem;
  logic [CW:0]   wr_sum;
  logic          wr_wrap;

  assign div_start = (state_q == ST_SETUP4) && present_q && (ov_c > CW'(1));
  assign wr_sum    = {1'b0, wr_q} + {1'b0, div_rem};
  assign wr_wrap   = wr_sum >= {1'b0, CW'(ov_c - 1'b1)};

  coc_div #(
    .NW (IW),
    .DW (CW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (IW'(COS_TABLE_SIZE - 1)),
    .divisor_i  (CW'(ov_c - 1'b1)),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  logic [coc_pkg::WGT_W-1:0] rom_w;

  coc_rom #(
    .T (COS_TABLE_SIZE)
  ) u_rom (
    .clk_i (clk_i),
    .idx_i (wq_q),
    .w_o   (rom_w)
  );

  // ---- walk issue / write-behind ----------------------------------------------
  logic          issue;
  logic [AW-1:0] chunk_raddr;
  logic          j_in_ov;

  assign issue       = (state_q == ST_WALK) && (j_q < len_q);
  assign chunk_raddr = base_q + j_q[AW-1:0];
  assign j_in_ov     = j_q >= off_q;

  // Q1.15 crossfade: floor((held*(1-w) + new*w + half) / one), saturated
  logic [16:0]          w_mix, wc_mix;
  logic signed [SW-1:0] mix_s, mix_r;
  logic signed [SB-1:0] mix_out, wr_data;

  assign w_mix   = p_one_q ? 17'd32768 : {1'b0, rom_w};
  assign wc_mix  = 17'd32768 - w_mix;
  assign mix_s   = SW'(held_rd_q) * SW'($signed({1'b0, wc_mix}))
                 + SW'(chunk_rd_q) * SW'($signed({1'b0, w_mix})) + HALF;
  assign mix_r   = mix_s >>> 15;
  assign mix_out = (mix_r > SMAX) ? SB'(SMAX) : (mix_r < SMIN) ? SB'(SMIN) : SB'(mix_r);

  always_comb begin
    case (pass_q)
      PASS_MIX:   wr_data = p_mix_q ? mix_out : held_rd_q;
      PASS_FLUSH: wr_data = held_rd_q;
      default:    wr_data = chunk_rd_q;
    endcase
  end

  // ---- memories ---------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (load_store) begin
      chunk_mem[fill_q[AW-1:0]] <= sample_in_i;
    end
    chunk_rd_q <= chunk_mem[chunk_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (p_vld_q && (pass_q == PASS_KEEP)) begin
      held_mem[p_addr_q] <= wr_data;
    end
    held_rd_q <= held_mem[j_q[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (p_vld_q && (pass_q != PASS_KEEP)) begin
      drain_mem[p_addr_q] <= wr_data;
    end
    drain_rd_q <= drain_mem[drain_ptr_q[AW-1:0]];
  end

  // ---- control ----------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q     <= coc_pkg::FRAME_RESET;
      look_q      <= '0;
      blend_q     <= '0;
      state_q     <= ST_IDLE;
      pass_q      <= PASS_KEEP;
      fill_q      <= '0;
      held_len_q  <= '0;
      present_q   <= 1'b0;
      drain_len_q <= '0;
      drain_ptr_q <= '0;
      j_q         <= '0;
      len_q       <= '0;
      n_q         <= '0;
      mb_q        <= '0;
      me_q        <= '0;
      cb_q        <= '0;
      lead_q      <= '0;
      off_q       <= '0;
      base_q      <= '0;
      hist_q      <= '0;
      hs_q        <= '0;
      fs_q        <= '0;
      one_q       <= 1'b0;
      wq_q        <= '0;
      wr_q        <= '0;
      p_vld_q     <= 1'b0;
      p_mix_q     <= 1'b0;
      p_one_q     <= 1'b0;
      p_addr_q    <= '0;
      pend_q      <= 1'b0;
      pend_vld_q  <= 1'b0;
      pend_last_q <= 1'b0;
      pend_stat_q <= coc_pkg::STAT_OK;
      res_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      sample_q    <= '0;
      last_q      <= 1'b0;
      status_q    <= coc_pkg::STAT_OK;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          coc_pkg::CFG_FRAME:     frame_q <= cfg_data_i[coc_pkg::FRAME_W-1:0];
          coc_pkg::CFG_LOOKAHEAD: look_q  <= cfg_data_i[coc_pkg::LOOK_W-1:0];
          coc_pkg::CFG_BLEND:     blend_q <= cfg_data_i[coc_pkg::BLEND_W-1:0];
          default: ;
        endcase
      end

      // result register; the slot is always free in the cycle after accept
      if (res_valid_q && !res_stall_i) begin
        res_valid_q <= 1'b0;
      end
      if (pend_q) begin
        pend_q      <= 1'b0;
        res_valid_q <= 1'b1;
        out_valid_q <= pend_vld_q;
        sample_q    <= pend_vld_q ? drain_rd_q : '0;
        last_q      <= pend_last_q;
        status_q    <= pend_stat_q;
      end

      p_vld_q  <= issue;
      p_addr_q <= j_q[AW-1:0];
      p_mix_q  <= j_in_ov;
      p_one_q  <= one_q;

      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            pend_q      <= 1'b1;
            pend_vld_q  <= 1'b0;
            pend_last_q <= 1'b0;
            pend_stat_q <= coc_pkg::STAT_OK;
            case (op)
              coc_pkg::OP_LOAD: begin
                if (chunk_end_i && busy) begin
                  pend_stat_q <= coc_pkg::STAT_BUSY;
                end else begin
                  if (full) begin
                    pend_stat_q <= coc_pkg::STAT_OVERFLOW;
                  end
                  fill_q <= n_new;
                  if (chunk_end_i) begin
                    fill_q <= '0;
                    n_q    <= n_new;
                    hist_q <= history_count_i;
                    if (bypass) begin
                      drain_len_q <= n_new;
                      drain_ptr_q <= '0;
                      pass_q      <= PASS_BYP;
                      j_q         <= '0;
                      len_q       <= n_new;
                      base_q      <= '0;
                      state_q     <= ST_WALK;
                    end else begin
                      state_q <= ST_SETUP1;
                    end
                  end
                end
              end
              coc_pkg::OP_DRAIN: begin
                if (busy) begin
                  pend_vld_q  <= 1'b1;
                  drain_ptr_q <= drain_ptr_q + 1'b1;
                  if (drain_ptr_q + 1'b1 >= drain_len_q) begin
                    pend_last_q <= 1'b1;
                    drain_ptr_q <= '0;
                    drain_len_q <= '0;
                  end
                end else begin
                  pend_stat_q <= coc_pkg::STAT_EMPTY;
                end
              end
              coc_pkg::OP_FLUSH: begin
                if (busy) begin
                  pend_stat_q <= coc_pkg::STAT_BUSY;
                end else if (present_q) begin
                  drain_len_q <= held_len_q;
                  drain_ptr_q <= '0;
                  held_len_q  <= '0;
                  present_q   <= 1'b0;
                  pass_q      <= PASS_FLUSH;
                  j_q         <= '0;
                  len_q       <= held_len_q;
                  base_q      <= '0;
                  state_q     <= ST_WALK;
                end
              end
              default: ;
            endcase
          end
        end
        ST_SETUP1: begin
          hs_q    <= WW'(hist_q) * WW'(frame_q);
          fs_q    <= WW'(look_q) * WW'(frame_q);
          state_q <= ST_SETUP2;
        end
        ST_SETUP2: begin
          mb_q    <= mb_c;
          me_q    <= (me_c < mb_c) ? mb_c : me_c;
          state_q <= ST_SETUP3;
        end
        ST_SETUP3: begin
          cb_q    <= cb_c;
          lead_q  <= mb_q - cb_c;
          state_q <= ST_SETUP4;
        end
        ST_SETUP4: begin
          if (present_q) begin
            drain_len_q <= held_len_q;
            drain_ptr_q <= '0;
            off_q       <= held_len_q - ov_c;
            base_q      <= AW'(cb_q) - AW'(held_len_q - ov_c);
            one_q       <= ov_c <= CW'(1);
            wq_q        <= '0;
            wr_q        <= CW'((ov_c - 1'b1) >> 1);
            pass_q      <= PASS_MIX;
            j_q         <= '0;
            len_q       <= held_len_q;
            state_q     <= (ov_c > CW'(1)) ? ST_DIV : ST_WALK;
          end else begin
            // first chunk: only hold the main region
            pass_q     <= PASS_KEEP;
            j_q        <= '0;
            len_q      <= me_q - mb_q;
            base_q     <= AW'(mb_q);
            held_len_q <= me_q - mb_q;
            present_q  <= 1'b1;
            state_q    <= ST_WALK;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (issue) begin
            j_q <= j_q + 1'b1;
            if (pass_q == PASS_MIX && j_in_ov) begin
              if (wr_wrap) begin
                wr_q <= CW'(wr_sum - {1'b0, CW'(ov_c - 1'b1)});
                wq_q <= wq_q + div_quo + 1'b1;
              end else begin
                wr_q <= wr_sum[CW-1:0];
                wq_q <= wq_q + div_quo;
              end
            end
          end else if (!p_vld_q) begin
            if (pass_q == PASS_MIX) begin
              pass_q     <= PASS_KEEP;
              j_q        <= '0;
              len_q      <= me_q - mb_q;
              base_q     <= AW'(mb_q);
              held_len_q <= me_q - mb_q;
              present_q  <= 1'b1;
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign res_valid_o  = res_valid_q;
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_q;
  assign run_last_o   = last_q;
  assign status_o     = status_q;

  // ---- assertions ---------------------------------------------------------------
  `include "chunk_overlap_crossfade_unit_defines.svh"

  `COC_ASSERT_NXT(a_accept_pends, in_valid_i && !in_stall_o, pend_q, "no result pending")
  `COC_ASSERT_IMP(a_ptr_range, 1'b1, drain_ptr_q <= drain_len_q, "drain pointer past length")
  `COC_ASSERT_IMP(a_quiet_sample, res_valid_o && !out_valid_o, sample_out_o == '0, "stray sample")
  `COC_ASSERT_IMP(a_walk_stalls, state_q != ST_IDLE, in_stall_o, "request taken during walk")

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Chunk overlap crossfade unit testbench
// Drives load, drain, flush and idle requests with random gaps and random
// result stalls. A scoreboard class keeps its own model of the chunk, held and
// drain stores and checks each result in order. Several register settings are
// covered, the pass-through ones among them and one with 4096-sample frames.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STORE_DEPTH = 8192;
  localparam int unsigned ROM_SIZE    = 256;
  localparam logic [1:0]  OP_IDLE     = 2'd3;  // unused opcode, no effect
  localparam int unsigned CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic               out_valid;
    logic signed [15:0] sample_out;
    logic               run_last;
    logic [1:0]         status;
  } crossfade_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: stitching model plus queue of expected results
  // --------------------------------------------------------------------------
  class crossfade_scoreboard;
    crossfade_result_t expected_q[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned overflow_hits;
    int unsigned busy_hits;
    int unsigned frame_len, look_frames, window_len;
    logic [15:0] hann_weight[ROM_SIZE];
    int chunk_mem[STORE_DEPTH];
    int held_mem[STORE_DEPTH];
    int drain_mem[STORE_DEPTH];
    int unsigned chunk_cnt, held_cnt, drain_cnt, drain_rd;
    bit held_valid;

    function new();
      longint unsigned last, m, theta, c, v, t2, h, term;
      longint unsigned divs[6];
      divs = '{132, 90, 56, 30, 12, 2};
      last = ROM_SIZE - 1;
      for (int k = 0; k < ROM_SIZE; k++) begin
        m     = (2 * k <= last) ? k : last - k;
        theta = (64'd3373259426 * m + last / 2) / last;
        t2    = (theta * theta) >> 30;
        h     = 64'd1 << 30;
        for (int j = 0; j < 6; j++) begin
          term = ((t2 * h) >> 30) / divs[j];
          h    = (term > (64'd1 << 30)) ? 0 : (64'd1 << 30) - term;
        end
        c = h;
        v = (2 * k <= last) ? ((64'd1 << 30) - c) >> 1 : ((64'd1 << 30) + c) >> 1;
        hann_weight[k] = 16'((v + 64'd16384) >> 15);
      end
      frame_len   = 1024;
      look_frames = 0;
      window_len  = 0;
      chunk_cnt   = 0;
      held_cnt    = 0;
      held_valid  = 0;
      drain_cnt   = 0;
      drain_rd    = 0;
    endfunction

    function void set_reg(logic [1:0] idx, int unsigned val);
      if (idx == coc_pkg::CFG_FRAME) frame_len = val & 13'h1fff;
      else if (idx == coc_pkg::CFG_LOOKAHEAD) look_frames = val & 5'h1f;
      else if (idx == coc_pkg::CFG_BLEND) window_len = val & 13'h1fff;
    endfunction

    function int unsigned pending_drain();
      return drain_cnt - drain_rd;
    endfunction

    function int unsigned fade_weight(int unsigned i, int unsigned cnt);
      longint unsigned idx;
      if (cnt <= 1) return 32768;
      idx = (longint'(i) * (ROM_SIZE - 1) + (cnt - 1) / 2) / (cnt - 1);
      if (idx > ROM_SIZE - 1) idx = ROM_SIZE - 1;
      return hann_weight[idx];
    endfunction

    function int blend(int cur, int nxt, int unsigned w);
      longint s;
      s = longint'(cur) * (32768 - longint'(w)) + longint'(nxt) * longint'(w) + 16384;
      s = s >>> 15;  // floor divide
      if (s > 32767) s = 32767;
      if (s < -32768) s = -32768;
      return int'(s);
    endfunction

    function void close_chunk(int unsigned hist);
      int unsigned n, mb, me, cb, lead, ov, off;
      longint unsigned hs, fs;
      n = chunk_cnt;
      chunk_cnt = 0;
      if (n == 0) return;
      if (frame_len == 0 || (look_frames == 0 && window_len == 0)) begin
        for (int i = 0; i < n; i++) drain_mem[i] = chunk_mem[i];
        drain_cnt = n;
        drain_rd  = 0;
        return;
      end
      hs = longint'(hist) * frame_len;
      fs = longint'(look_frames) * frame_len;
      mb = (hs < n) ? int'(hs) : n;
      me = (fs < n) ? n - int'(fs) : 0;
      if (me < mb) me = mb;
      cb   = (mb > window_len) ? mb - window_len : 0;
      lead = mb - cb;
      if (held_valid) begin
        ov  = (lead < held_cnt) ? lead : held_cnt;
        off = held_cnt - ov;
        for (int i = 0; i < held_cnt; i++) drain_mem[i] = held_mem[i];
        for (int i = 0; i < ov; i++)
          drain_mem[off+i] = blend(held_mem[off+i], chunk_mem[cb+i], fade_weight(i, ov));
        drain_cnt = held_cnt;
        drain_rd  = 0;
      end
      for (int i = 0; i < me - mb; i++) held_mem[i] = chunk_mem[mb+i];
      held_cnt   = me - mb;
      held_valid = 1;
    endfunction

    function void note_request(logic [1:0] op, logic signed [15:0] smp, logic last_smp,
                               logic [6:0] hist);
      crossfade_result_t r;
      bit busy;
      busy = drain_rd < drain_cnt;
      r = '0;
      if (op == coc_pkg::OP_LOAD) begin
        if (last_smp && busy) begin
          r.status = coc_pkg::STAT_BUSY;
        end else begin
          if (chunk_cnt < STORE_DEPTH) begin
            chunk_mem[chunk_cnt] = smp;
            chunk_cnt++;
          end else begin
            r.status = coc_pkg::STAT_OVERFLOW;
          end
          if (last_smp) close_chunk(hist);
        end
      end else if (op == coc_pkg::OP_DRAIN) begin
        if (busy) begin
          r.out_valid  = 1'b1;
          r.sample_out = 16'(drain_mem[drain_rd]);
          drain_rd++;
          if (drain_rd >= drain_cnt) begin
            r.run_last = 1'b1;
            drain_rd   = 0;
            drain_cnt  = 0;
          end
        end else begin
          r.status = coc_pkg::STAT_EMPTY;
        end
      end else if (op == coc_pkg::OP_FLUSH) begin
        if (busy) begin
          r.status = coc_pkg::STAT_BUSY;
        end else if (held_valid) begin
          for (int i = 0; i < held_cnt; i++) drain_mem[i] = held_mem[i];
          drain_cnt  = held_cnt;
          drain_rd   = 0;
          held_cnt   = 0;
          held_valid = 0;
        end
      end
      if (r.status == coc_pkg::STAT_OVERFLOW) overflow_hits++;
      if (r.status == coc_pkg::STAT_BUSY) busy_hits++;
      expected_q.push_back(r);
    endfunction

    function void check_result(crossfade_result_t act);
      crossfade_result_t exp_r;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", act);
        return;
      end
      exp_r = expected_q.pop_front();
      checked++;
      if (act.out_valid !== exp_r.out_valid || act.sample_out !== exp_r.sample_out ||
          act.run_last !== exp_r.run_last || act.status !== exp_r.status) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d mismatch: exp valid=%0b smp=%0d last=%0b st=%0d",
                   checked, exp_r.out_valid, exp_r.sample_out, exp_r.run_last,
                   exp_r.status);
          $display("  act valid=%0b smp=%0d last=%0b st=%0d",
                   act.out_valid, act.sample_out, act.run_last, act.status);
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] opcode_i = OP_IDLE;
  logic signed [15:0] sample_in_i = '0;
  logic chunk_end_i = 1'b0;
  logic [coc_pkg::HIST_W-1:0] history_count_i = '0;
  logic res_valid_o;
  logic res_stall_i = 1'b0;
  logic out_valid_o;
  logic signed [15:0] sample_out_o;
  logic run_last_o;
  logic [1:0] status_o;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [coc_pkg::CFG_W-1:0] cfg_data_i = '0;

  always #5 clk_i = ~clk_i;

  chunk_overlap_crossfade_unit dut (.*);

  crossfade_scoreboard sb = new();
  bit quiet_mode;          // no idling on either side while set
  int unsigned walk_guard; // longest chunk since the last quiet point
  int unsigned cycle_count;

  // Mostly short gaps, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet_mode || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Result-side stall generator: one nonblocking update per edge.
  int unsigned stall_left;
  always @(posedge clk_i) begin
    logic nxt;
    nxt = 1'b0;
    if (stall_left > 0) begin
      stall_left--;
      nxt = 1'b1;
    end else if (!quiet_mode && $urandom_range(0, 9) < 3) begin
      stall_left = pick_gap();
    end
    res_stall_i <= nxt;
  end

  // Result monitor: sampled mid-cycle, the accept happens at the next edge.
  always @(negedge clk_i) begin
    if (rst_ni && res_valid_o && !res_stall_i)
      sb.check_result('{out_valid_o, sample_out_o, run_last_o, status_o});
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Entered right after a rising edge; returns right after the accept edge,
  // leaving valid high so back-to-back requests need no extra NBA.
  task automatic send_req(logic [1:0] op, logic signed [15:0] smp, logic last_smp,
                          logic [6:0] hist);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    opcode_i        <= op;
    sample_in_i     <= smp;
    chunk_end_i     <= last_smp;
    history_count_i <= hist;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    sb.note_request(op, smp, last_smp, hist);
    @(posedge clk_i);
  endtask

  // Wait for all results, then for any trailing walk to finish.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (3 * walk_guard + 100) @(posedge clk_i);
    walk_guard = 0;
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= coc_pkg::CFG_W'(val);
    sb.set_reg(idx, val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_mode(int unsigned fr, int unsigned la, int unsigned bw);
    settle();
    write_reg(coc_pkg::CFG_FRAME, fr);
    write_reg(coc_pkg::CFG_LOOKAHEAD, la);
    write_reg(coc_pkg::CFG_BLEND, bw);
  endtask

  function automatic logic signed [15:0] rand_sample();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'sh7fff;
    if (r == 1) return 16'sh8000;
    return 16'($urandom);
  endfunction

  function automatic logic [6:0] rand_hist();
    if ($urandom_range(0, 9) == 0) return 7'($urandom);
    return 7'($urandom_range(0, 4));
  endfunction

  task automatic load_chunk(int unsigned len, logic [6:0] hist);
    if (len > walk_guard) walk_guard = len;
    for (int unsigned i = 1; i <= len; i++)
      send_req(coc_pkg::OP_LOAD, rand_sample(), i == len, hist);
  endtask

  task automatic drain_all(int unsigned extra);
    int unsigned n;
    n = sb.pending_drain();
    repeat (n + extra) send_req(coc_pkg::OP_DRAIN, 16'($urandom), 1'($urandom), 7'($urandom));
  endtask

  task automatic random_phase(int unsigned items);
    int unsigned sent, r, len;
    sent = 0;
    while (sent < items) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
        load_chunk(len, rand_hist());
        // an early end or flush while the queue is busy
        if ($urandom_range(0, 4) == 0)
          send_req(coc_pkg::OP_LOAD, rand_sample(), 1'b1, rand_hist());
        if ($urandom_range(0, 4) == 0)
          send_req(coc_pkg::OP_FLUSH, 16'($urandom), 1'($urandom), '0);
        sent += len + sb.pending_drain();
        drain_all($urandom_range(0, 1));
      end else if (r < 85) begin
        send_req(coc_pkg::OP_FLUSH, 16'($urandom), 1'($urandom), 7'($urandom));
        sent += 1 + sb.pending_drain();
        drain_all(0);
      end else begin
        send_req(2'($urandom_range(0, 3)), rand_sample(), 1'($urandom), 7'($urandom));
        sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    quiet_mode = 0;
    walk_guard = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty drain, empty flush, idle opcode, then a crossfaded pair.
    send_req(coc_pkg::OP_DRAIN, 16'sh7fff, 1'b1, 7'h7f);
    send_req(coc_pkg::OP_FLUSH, 16'sh8000, 1'b0, 7'h00);
    send_req(OP_IDLE, 16'sh1234, 1'b1, 7'h40);
    set_mode(4, 1, 3);
    load_chunk(12, 7'd1);          // first chunk: held only
    load_chunk(10, 7'd2);          // crossfade with the held tail
    send_req(coc_pkg::OP_LOAD, 16'sh8000, 1'b1, 7'd1);  // busy chunk end
    send_req(coc_pkg::OP_FLUSH, 16'sh7fff, 1'b0, 7'd0); // busy flush
    drain_all(1);
    send_req(coc_pkg::OP_FLUSH, 16'sh0000, 1'b0, 7'd0);
    drain_all(0);

    // Random phases over several settings, extremes among them.
    set_mode(4096, 16, 4096);
    random_phase(25);
    set_mode(1, 0, 0);
    random_phase(25);
    set_mode(1, 0, 5);
    random_phase(30);
    set_mode(3, 2, 7);
    quiet_mode = 1;
    random_phase(25);
    quiet_mode = 0;
    // sender holds off until everything has come back
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    random_phase(25);
    set_mode(0, 3, 9);
    random_phase(25);
    for (int p = 0; p < 3; p++) begin
      set_mode($urandom_range(1, 8), $urandom_range(0, 3), $urandom_range(0, 20));
      random_phase(25);
    end
    settle();

    $display("checked %0d results over 9 register settings", sb.checked);
    $display("busy rejects %0d, store overflows %0d", sb.busy_hits, sb.overflow_hits);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.expected_q.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
